FILE: rtl/core/button_press_gesture_qualifier_core_defines.svh
// Assertion macros shared by the gesture qualifier RTL.
// They expect a clock named clk and an active-low reset named arst_n in scope.
`ifndef BUTTON_PRESS_GESTURE_QUALIFIER_CORE_DEFINES_SVH
`define BUTTON_PRESS_GESTURE_QUALIFIER_CORE_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define BPGQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define BPGQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/bpgq_pkg.sv
package bpgq_pkg;

	localparam int unsigned TimeW = 32;
	localparam int unsigned LimW  = 16;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned KeyW  = 3;

	typedef logic [TimeW-1:0] time_ms_t;
	typedef logic [LimW-1:0]  limit_t;
	typedef logic [IdxW-1:0]  reg_idx_t;
	typedef logic [KeyW-1:0]  key_code_t;

	localparam reg_idx_t REG_LONG_PRESS    = 3'd0;
	localparam reg_idx_t REG_SHORT_MIN     = 3'd1;
	localparam reg_idx_t REG_SHORT_MAX     = 3'd2;
	localparam reg_idx_t REG_RESTART_HOLD  = 3'd3;
	localparam reg_idx_t REG_REPEAT_DELAY  = 3'd4;
	localparam reg_idx_t REG_REPEAT_PERIOD = 3'd5;

	localparam limit_t LONG_PRESS_RST    = 16'd3000;
	localparam limit_t SHORT_MIN_RST     = 16'd50;
	localparam limit_t SHORT_MAX_RST     = 16'd1000;
	localparam limit_t RESTART_HOLD_RST  = 16'd5000;
	localparam limit_t REPEAT_DELAY_RST  = 16'd400;
	localparam limit_t REPEAT_PERIOD_RST = 16'd80;

	localparam key_code_t KEY_NONE  = 3'd0;
	localparam key_code_t KEY_UP    = 3'd1;
	localparam key_code_t KEY_DOWN  = 3'd2;
	localparam key_code_t KEY_LEFT  = 3'd3;
	localparam key_code_t KEY_RIGHT = 3'd4;

	typedef struct packed {
		limit_t long_press_ms;
		limit_t short_min_ms;
		limit_t short_max_ms;
		limit_t restart_hold_ms;
		limit_t repeat_delay_ms;
		limit_t repeat_period_ms;
	} cfg_t;

	typedef struct packed {
		time_ms_t now_ms;
		logic     power_level;
		logic     back_level;
		logic     up_level;
		logic     down_level;
		logic     left_level;
		logic     right_level;
		logic     repeat_enable;
	} sample_t;

	typedef struct packed {
		logic      sleep_request;
		logic      short_press;
		logic      restart_request;
		key_code_t key_fire;
	} result_t;

endpackage

FILE: rtl/core/button_press_gesture_qualifier_core.sv
// Channel   Direction  Handshake            Beat contents
// sample    in         in_valid / in_stall  now_ms and the seven button and enable levels
// result    out        out_valid / out_stall sleep_request, short_press, restart_request, key_fire
//
// A sample beat is taken into an input register and evaluated there against the gesture
// state; its result is written into the output register when the pipeline advances.
// One beat is taken every cycle while in_stall is low.
// The input register keeps taking beats while the output register waits; a stall on the
// result side reaches in_stall only once both registers are full.
// Reset clears the handshake valids and the gesture state and loads the register defaults.
`include "button_press_gesture_qualifier_core_defines.svh"

module button_press_gesture_qualifier_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  bpgq_pkg::reg_idx_t  cfg_index,
	input  bpgq_pkg::limit_t    cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  bpgq_pkg::time_ms_t  now_ms,
	input  logic                power_level,
	input  logic                back_level,
	input  logic                up_level,
	input  logic                down_level,
	input  logic                left_level,
	input  logic                right_level,
	input  logic                repeat_enable,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                sleep_request,
	output logic                short_press,
	output logic                restart_request,
	output bpgq_pkg::key_code_t key_fire
);

	bpgq_pkg::cfg_t    cfg;
	bpgq_pkg::sample_t smp_s1;
	logic              valid_s1;
	bpgq_pkg::result_t res_comb;
	bpgq_pkg::result_t res_s2;
	logic              valid_s2;
	logic              advance;
	logic              in_take;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	bpgq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cfg      (cfg)
	);

	bpgq_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.advance(advance),
		.smp    (smp_s1),
		.cfg    (cfg),
		.res    (res_comb)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			smp_s1.now_ms        <= now_ms;
			smp_s1.power_level   <= power_level;
			smp_s1.back_level    <= back_level;
			smp_s1.up_level      <= up_level;
			smp_s1.down_level    <= down_level;
			smp_s1.left_level    <= left_level;
			smp_s1.right_level   <= right_level;
			smp_s1.repeat_enable <= repeat_enable;
		end
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid       = valid_s2;
	assign sleep_request   = res_s2.sleep_request;
	assign short_press     = res_s2.short_press;
	assign restart_request = res_s2.restart_request;
	assign key_fire        = res_s2.key_fire;

	`BPGQ_ASSERT_SAME(a_sleep_alone, valid_s2 && res_s2.sleep_request, !res_s2.short_press && !res_s2.restart_request && (res_s2.key_fire == bpgq_pkg::KEY_NONE), "sleep result carries other events")
	`BPGQ_ASSERT_SAME(a_key_range, valid_s2, res_s2.key_fire <= bpgq_pkg::KEY_RIGHT, "key code out of range")
	`BPGQ_ASSERT_SAME(a_stall_full, in_stall, valid_s1 && valid_s2 && out_stall, "input stalled with room in the pipeline")
	`BPGQ_ASSERT_NEXT(a_s1_hold, valid_s1 && !advance, valid_s1 && $stable(smp_s1), "held sample lost while blocked")

endmodule

FILE: rtl/core/bpgq_cfg.sv
module bpgq_cfg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  bpgq_pkg::reg_idx_t cfg_index,
	input  bpgq_pkg::limit_t   cfg_data,
	output bpgq_pkg::cfg_t     cfg
);

	bpgq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_press_ms    <= bpgq_pkg::LONG_PRESS_RST;
			cfg_q.short_min_ms     <= bpgq_pkg::SHORT_MIN_RST;
			cfg_q.short_max_ms     <= bpgq_pkg::SHORT_MAX_RST;
			cfg_q.restart_hold_ms  <= bpgq_pkg::RESTART_HOLD_RST;
			cfg_q.repeat_delay_ms  <= bpgq_pkg::REPEAT_DELAY_RST;
			cfg_q.repeat_period_ms <= bpgq_pkg::REPEAT_PERIOD_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bpgq_pkg::REG_LONG_PRESS:    cfg_q.long_press_ms    <= cfg_data;
				bpgq_pkg::REG_SHORT_MIN:     cfg_q.short_min_ms     <= cfg_data;
				bpgq_pkg::REG_SHORT_MAX:     cfg_q.short_max_ms     <= cfg_data;
				bpgq_pkg::REG_RESTART_HOLD:  cfg_q.restart_hold_ms  <= cfg_data;
				bpgq_pkg::REG_REPEAT_DELAY:  cfg_q.repeat_delay_ms  <= cfg_data;
				bpgq_pkg::REG_REPEAT_PERIOD: cfg_q.repeat_period_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/core/bpgq_eval.sv
module bpgq_eval (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  bpgq_pkg::sample_t smp,
	input  bpgq_pkg::cfg_t    cfg,
	output bpgq_pkg::result_t res
);

	logic                 power_held_q;
	bpgq_pkg::time_ms_t   power_start_q;
	logic                 sleep_fired_q;
	logic                 back_held_q;
	bpgq_pkg::time_ms_t   back_start_q;
	logic                 restart_fired_q;
	bpgq_pkg::key_code_t  repeat_code_q;
	bpgq_pkg::time_ms_t   repeat_begin_q;
	bpgq_pkg::time_ms_t   last_fire_q;

	logic                 p_fired_eff;
	bpgq_pkg::time_ms_t   p_start_eff;
	bpgq_pkg::time_ms_t   p_elapsed;
	bpgq_pkg::time_ms_t   p_dur;
	logic                 sleep_hit;
	logic                 short_hit;
	logic                 b_fired_eff;
	bpgq_pkg::time_ms_t   b_start_eff;
	bpgq_pkg::time_ms_t   b_elapsed;
	logic                 restart_hit;
	bpgq_pkg::key_code_t  held_code;
	bpgq_pkg::time_ms_t   r_since_begin;
	bpgq_pkg::time_ms_t   r_since_fire;
	logic                 code_change;
	logic                 repeat_hit;

	// A press that starts on this sample begins its hold at the sample time.
	always_comb begin
		p_fired_eff = sleep_fired_q;
		p_start_eff = power_start_q;
		if (smp.power_level && !power_held_q) begin
			p_fired_eff = 1'b0;
			p_start_eff = smp.now_ms;
		end
		p_elapsed = smp.now_ms - p_start_eff;
		p_dur     = smp.now_ms - power_start_q;
		sleep_hit = smp.power_level && !p_fired_eff &&
			(p_elapsed > {16'd0, cfg.long_press_ms});
		short_hit = !smp.power_level && power_held_q && !sleep_fired_q &&
			(p_dur > {16'd0, cfg.short_min_ms}) && (p_dur < {16'd0, cfg.short_max_ms});

		b_fired_eff = restart_fired_q;
		b_start_eff = back_start_q;
		if (smp.back_level && !back_held_q) begin
			b_fired_eff = 1'b0;
			b_start_eff = smp.now_ms;
		end
		b_elapsed   = smp.now_ms - b_start_eff;
		restart_hit = smp.back_level && !b_fired_eff &&
			(b_elapsed > {16'd0, cfg.restart_hold_ms});
	end

	always_comb begin
		priority if (smp.up_level)    held_code = bpgq_pkg::KEY_UP;
		else if (smp.down_level)      held_code = bpgq_pkg::KEY_DOWN;
		else if (smp.left_level)      held_code = bpgq_pkg::KEY_LEFT;
		else if (smp.right_level)     held_code = bpgq_pkg::KEY_RIGHT;
		else                          held_code = bpgq_pkg::KEY_NONE;
		r_since_begin = smp.now_ms - repeat_begin_q;
		r_since_fire  = smp.now_ms - last_fire_q;
		code_change   = smp.repeat_enable && (held_code != repeat_code_q);
		repeat_hit    = smp.repeat_enable && !code_change &&
			(held_code != bpgq_pkg::KEY_NONE) &&
			(r_since_begin > {16'd0, cfg.repeat_delay_ms}) &&
			(r_since_fire > {16'd0, cfg.repeat_period_ms});
	end

	always_comb begin
		res = '0;
		if (sleep_hit) begin
			res.sleep_request = 1'b1;
		end else begin
			res.short_press     = short_hit;
			res.restart_request = restart_hit;
			if (code_change || repeat_hit) begin
				res.key_fire = held_code;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			power_held_q    <= 1'b0;
			power_start_q   <= '0;
			sleep_fired_q   <= 1'b0;
			back_held_q     <= 1'b0;
			back_start_q    <= '0;
			restart_fired_q <= 1'b0;
			repeat_code_q   <= bpgq_pkg::KEY_NONE;
			repeat_begin_q  <= '0;
			last_fire_q     <= '0;
		end else if (advance) begin
			if (smp.power_level) begin
				power_held_q  <= 1'b1;
				power_start_q <= p_start_eff;
				sleep_fired_q <= p_fired_eff || sleep_hit;
			end else begin
				power_held_q  <= 1'b0;
			end
			if (!sleep_hit) begin
				back_held_q <= smp.back_level;
				if (smp.back_level) begin
					back_start_q    <= b_start_eff;
					restart_fired_q <= b_fired_eff || restart_hit;
				end
				if (code_change) begin
					repeat_code_q  <= held_code;
					repeat_begin_q <= smp.now_ms;
					last_fire_q    <= smp.now_ms;
				end else if (repeat_hit) begin
					last_fire_q    <= smp.now_ms;
				end
			end
		end
	end

endmodule

FILE: tb/tb_button_press_gesture_qualifier_core.sv
module tb_button_press_gesture_qualifier_core;
	timeunit 1ns;
	timeprecision 1ps;

	import bpgq_pkg::*;

	localparam bit [6:0] B_PWR = 7'b1000000;
	localparam bit [6:0] B_BCK = 7'b0100000;
	localparam bit [6:0] B_UP  = 7'b0010000;
	localparam bit [6:0] B_DN  = 7'b0001000;
	localparam bit [6:0] B_LF  = 7'b0000100;
	localparam bit [6:0] B_RT  = 7'b0000010;
	localparam bit [6:0] B_REP = 7'b0000001;

	localparam int unsigned WATCHDOG_LIMIT  = 2000;
	localparam int unsigned HOLD_OFF_CYCLES = 80;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_we = 1'b0;
	reg_idx_t  cfg_index = REG_LONG_PRESS;
	limit_t    cfg_data = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	time_ms_t  now_ms = '0;
	logic      power_level = 1'b0;
	logic      back_level = 1'b0;
	logic      up_level = 1'b0;
	logic      down_level = 1'b0;
	logic      left_level = 1'b0;
	logic      right_level = 1'b0;
	logic      repeat_enable = 1'b0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	logic      sleep_request;
	logic      short_press;
	logic      restart_request;
	key_code_t key_fire;

	cfg_t      cur_cfg;
	logic      pwr_held, sleep_done, bck_held, restart_done;
	time_ms_t  pwr_t0, bck_t0, rep_t0, last_fire;
	key_code_t rep_key;
	result_t   expected_q[$];
	bit [6:0]  levels = B_REP;
	time_ms_t  clock_ms = '0;

	int unsigned snd_idle_pct = 0;
	int unsigned rcv_idle_pct = 0;
	int unsigned hold_left = 0;
	bit          hold_off_req = 1'b0;
	bit          hold_off_done = 1'b0;
	int unsigned idle_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned n_samples = 0;
	int unsigned n_results = 0;
	int unsigned n_sleep = 0;
	int unsigned n_short = 0;
	int unsigned n_restart = 0;
	int unsigned n_keys = 0;

	button_press_gesture_qualifier_core dut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic result_t qualify_sample(input sample_t s);
		result_t   r;
		key_code_t held;
		time_ms_t  dur;
		r = '0;
		if (s.power_level && !pwr_held) begin
			pwr_held = 1'b1;
			sleep_done = 1'b0;
			pwr_t0 = s.now_ms;
		end
		dur = s.now_ms - pwr_t0;
		if (s.power_level && !sleep_done && dur > cur_cfg.long_press_ms) begin
			sleep_done = 1'b1;
			r.sleep_request = 1'b1;
			return r;
		end
		if (!s.power_level && pwr_held) begin
			pwr_held = 1'b0;
			if (!sleep_done && dur > cur_cfg.short_min_ms && dur < cur_cfg.short_max_ms)
				r.short_press = 1'b1;
		end

		if (s.back_level && !bck_held) begin
			bck_held = 1'b1;
			restart_done = 1'b0;
			bck_t0 = s.now_ms;
		end
		dur = s.now_ms - bck_t0;
		if (s.back_level && !restart_done && dur > cur_cfg.restart_hold_ms) begin
			restart_done = 1'b1;
			r.restart_request = 1'b1;
		end
		if (!s.back_level)
			bck_held = 1'b0;

		if (s.repeat_enable) begin
			if (s.up_level)
				held = KEY_UP;
			else if (s.down_level)
				held = KEY_DOWN;
			else if (s.left_level)
				held = KEY_LEFT;
			else if (s.right_level)
				held = KEY_RIGHT;
			else
				held = KEY_NONE;
			if (held != rep_key) begin
				r.key_fire = held;
				rep_key = held;
				rep_t0 = s.now_ms;
				last_fire = s.now_ms;
			end else if (held != KEY_NONE) begin
				if (time_ms_t'(s.now_ms - rep_t0) > cur_cfg.repeat_delay_ms &&
				    time_ms_t'(s.now_ms - last_fire) > cur_cfg.repeat_period_ms) begin
					r.key_fire = held;
					last_fire = s.now_ms;
				end
			end
		end
		return r;
	endfunction

	task automatic send_sample(input sample_t s);
		int unsigned gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < snd_idle_pct)
			gap++;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= s.now_ms;
		power_level <= s.power_level;
		back_level <= s.back_level;
		up_level <= s.up_level;
		down_level <= s.down_level;
		left_level <= s.left_level;
		right_level <= s.right_level;
		repeat_enable <= s.repeat_enable;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		expected_q.push_back(qualify_sample(s));
		n_samples++;
	endtask

	task automatic sample_after(input time_ms_t dt, input bit [6:0] lv);
		sample_t s;
		clock_ms = clock_ms + dt;
		s.now_ms = clock_ms;
		{s.power_level, s.back_level, s.up_level, s.down_level,
		 s.left_level, s.right_level, s.repeat_enable} = lv;
		send_sample(s);
	endtask

	task automatic random_sample();
		limit_t      lims[6];
		int unsigned pick;
		time_ms_t    dt;
		lims = '{cur_cfg.long_press_ms, cur_cfg.short_min_ms, cur_cfg.short_max_ms,
		         cur_cfg.restart_hold_ms, cur_cfg.repeat_delay_ms, cur_cfg.repeat_period_ms};
		if ($urandom_range(99) < 20) levels ^= B_PWR;
		if ($urandom_range(99) < 20) levels ^= B_BCK;
		if ($urandom_range(99) < 15) levels ^= B_UP;
		if ($urandom_range(99) < 15) levels ^= B_DN;
		if ($urandom_range(99) < 15) levels ^= B_LF;
		if ($urandom_range(99) < 15) levels ^= B_RT;
		if ($urandom_range(99) < 5) levels ^= B_REP;
		pick = $urandom_range(99);
		if (pick < 30)
			dt = $urandom_range(3);
		else if (pick < 65)
			dt = time_ms_t'(lims[$urandom_range(5)]) + $urandom_range(2) - 1;
		else if (pick < 90)
			dt = $urandom_range(2000);
		else
			dt = $urandom();
		sample_after(dt, levels);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic apply_cfg(input cfg_t c);
		reg_idx_t idx_list[6];
		limit_t   vals[6];
		idx_list = '{REG_LONG_PRESS, REG_SHORT_MIN, REG_SHORT_MAX,
		             REG_RESTART_HOLD, REG_REPEAT_DELAY, REG_REPEAT_PERIOD};
		vals = '{c.long_press_ms, c.short_min_ms, c.short_max_ms,
		         c.restart_hold_ms, c.repeat_delay_ms, c.repeat_period_ms};
		for (int i = 0; i < 6; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= idx_list[i];
			cfg_data <= vals[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		cur_cfg = c;
	endtask

	function automatic limit_t random_limit();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 15)
			return '0;
		else if (pick < 30)
			return '1;
		else if (pick < 85)
			return limit_t'($urandom_range(6000));
		return limit_t'($urandom());
	endfunction

	task automatic random_run(input int unsigned count);
		repeat (count) random_sample();
		drain();
	endtask

	task automatic test_directed_defaults();
		snd_idle_pct = 8;
		rcv_idle_pct = 81;
		sample_after(0, '0);
		sample_after(10, B_PWR);
		sample_after(50, '0);
		sample_after(5, B_PWR);
		sample_after(51, '0);
		sample_after(5, B_PWR);
		sample_after(999, '0);
		sample_after(5, B_PWR);
		sample_after(1000, '0);
		// A power hold that reaches sleep on the same sample as a held back button.
		sample_after(5, B_PWR | B_BCK);
		sample_after(3000, B_PWR | B_BCK);
		sample_after(1, B_PWR | B_BCK);
		sample_after(2000, B_PWR | B_BCK);
		sample_after(10, '0);
		sample_after(10, B_REP | B_UP | B_DN);
		sample_after(400, B_REP | B_UP | B_DN);
		sample_after(1, B_REP | B_UP);
		sample_after(80, B_REP | B_UP);
		sample_after(1, B_REP | B_UP);
		sample_after(5, B_REP | B_DN | B_LF | B_RT);
		sample_after(5, B_REP | B_LF | B_RT);
		sample_after(5, B_REP | B_RT);
		sample_after(5, B_RT);
		sample_after(5, B_REP);
		// A short press whose start sits at the top of the timestamp range.
		clock_ms = 32'hFFFF_FFEF;
		sample_after(16, B_PWR);
		sample_after(100, '0);
		drain();
	endtask

	task automatic test_random_defaults();
		levels = B_REP;
		random_run(150);
	endtask

	task automatic test_zero_limits();
		snd_idle_pct = 81;
		rcv_idle_pct = 8;
		apply_cfg('0);
		random_run(80);
	endtask

	task automatic test_max_limits();
		apply_cfg('1);
		random_run(80);
	endtask

	task automatic test_receiver_hold_off();
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		apply_cfg('{LONG_PRESS_RST, SHORT_MIN_RST, SHORT_MAX_RST,
		            RESTART_HOLD_RST, REPEAT_DELAY_RST, REPEAT_PERIOD_RST});
		hold_off_req = 1'b1;
		random_run(40);
	endtask

	task automatic test_random_limits();
		cfg_t c;
		repeat (4) begin
			c = '{random_limit(), random_limit(), random_limit(),
			      random_limit(), random_limit(), random_limit()};
			apply_cfg(c);
			random_run(45);
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{sleep_request, short_press, restart_request, key_fire};
			n_results++;
			n_sleep += got.sleep_request;
			n_short += got.short_press;
			n_restart += got.restart_request;
			if (got.key_fire != KEY_NONE)
				n_keys++;
			if (expected_q.size() == 0) begin
				mismatches++;
				$display("%0t: result beat with nothing expected, actual sleep=%0b short=%0b restart=%0b key=%0d",
				         $time, got.sleep_request, got.short_press, got.restart_request,
				         got.key_fire);
			end else begin
				want = expected_q.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: expected sleep=%0b short=%0b restart=%0b key=%0d",
					         $time, want.sleep_request, want.short_press,
					         want.restart_request, want.key_fire);
					$display("%0t:   actual sleep=%0b short=%0b restart=%0b key=%0d",
					         $time, got.sleep_request, got.short_press,
					         got.restart_request, got.key_fire);
				end
			end
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_off_req && !hold_off_done) begin
			out_stall <= 1'b1;
			hold_left <= HOLD_OFF_CYCLES;
			hold_off_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat moved for %0d cycles", $time, idle_cycles);
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		cur_cfg = '{LONG_PRESS_RST, SHORT_MIN_RST, SHORT_MAX_RST,
		            RESTART_HOLD_RST, REPEAT_DELAY_RST, REPEAT_PERIOD_RST};
		pwr_held = 1'b0;
		sleep_done = 1'b0;
		bck_held = 1'b0;
		restart_done = 1'b0;
		pwr_t0 = '0;
		bck_t0 = '0;
		rep_t0 = '0;
		last_fire = '0;
		rep_key = KEY_NONE;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_defaults();
		test_random_defaults();
		test_zero_limits();
		test_max_limits();
		test_receiver_hold_off();
		test_random_limits();

		repeat (10) @(posedge clk);
		$display("Ran %0d samples and checked %0d results under default, zero, full-scale",
		         n_samples, n_results);
		$display("and random limits: %0d sleep, %0d short press, %0d restart, %0d key firings.",
		         n_sleep, n_short, n_restart, n_keys);
		if (mismatches == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
